[design/assert_macros.svh]
// Assertion macros used by the top level of the page replacement unit.
// Bodies collapse to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define LPR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LPR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LPR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define LPR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

[design/lpr_pkg.sv]
// Shared constants, types and control structs of the LRU page replacement unit.
// Used by the interfaces, the register block, the controller and the datapath.
`default_nettype none

package lpr_pkg;

    localparam int FRAME_COUNT = 4;
    localparam int PAGE_BITS   = 8;

    localparam int IDX_W   = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int CNT_W   = $clog2(FRAME_COUNT + 1);
    localparam int FIDX_W  = 2;
    localparam int FAULT_W = 16;
    localparam int CFG_W   = 3;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};
    localparam logic [IDX_W-1:0]   RANK_MAX  = IDX_W'(FRAME_COUNT - 1);
    localparam logic [CFG_W-1:0]   FRAMES_IN_USE_RESET = CFG_W'(4);

    // register index, taken from paddr[ADDR_W-1:2]
    localparam logic [ADDR_W-3:0] REG_FRAMES_IN_USE = '0;

    typedef logic [PAGE_BITS-1:0] page_t;
    typedef logic [IDX_W-1:0]     rank_t;
    typedef logic [FAULT_W-1:0]   fault_cnt_t;

    typedef struct packed {
        logic capture;
        logic exec;
    } lpr_cmd_t;

    typedef struct packed {
        logic rsp_stalled;
    } lpr_sts_t;

endpackage

`default_nettype wire

[design/lpr_req_if.sv]
// Request channel: one page reference per word.
// Depends on lpr_pkg for the page type.
`default_nettype none

interface lpr_req_if;
    logic           valid;
    logic           ready;
    lpr_pkg::page_t page_number;
    logic           first_of_run;

    modport source (output valid, output page_number, output first_of_run, input ready);
    modport sink   (input valid, input page_number, input first_of_run, output ready);
endinterface

`default_nettype wire

[design/lpr_rsp_if.sv]
// Result channel: one lookup outcome per word.
// Depends on lpr_pkg for widths and types.
`default_nettype none

interface lpr_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           fault;
    logic [lpr_pkg::FIDX_W-1:0]     frame_index;
    logic                           evicted_valid;
    lpr_pkg::page_t                 evicted_page;
    lpr_pkg::fault_cnt_t            fault_count;

    modport source (output valid, output fault, output frame_index, output evicted_valid,
                    output evicted_page, output fault_count, input ready);
    modport sink   (input valid, input fault, input frame_index, input evicted_valid,
                    input evicted_page, input fault_count, output ready);
endinterface

`default_nettype wire

[design/lpr_cfg_regs.sv]
// APB-style configuration register block: holds frames_in_use.
// Depends on lpr_pkg for widths, reset value and register index.
`default_nettype none

module lpr_cfg_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lpr_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [lpr_pkg::DATA_W-1:0]  pwdata,
    output logic      [lpr_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic      [lpr_pkg::CFG_W-1:0]   frames_in_use
);

    logic [lpr_pkg::CFG_W-1:0] frames_in_use_reg;
    logic [lpr_pkg::CFG_W-1:0] frames_in_use_next;
    logic                      sel_frames;

    assign sel_frames = (paddr[lpr_pkg::ADDR_W-1:2] == lpr_pkg::REG_FRAMES_IN_USE);

    always_comb
    begin
        frames_in_use_next = frames_in_use_reg;
        if (psel && penable && pwrite && sel_frames)
        begin
            frames_in_use_next = pwdata[lpr_pkg::CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= lpr_pkg::FRAMES_IN_USE_RESET;
        end
        else
        begin
            frames_in_use_reg <= frames_in_use_next;
        end
    end

    assign prdata = sel_frames ? lpr_pkg::DATA_W'(frames_in_use_reg) : '0;
    assign pready = 1'b1;
    assign frames_in_use = frames_in_use_reg;

endmodule

`default_nettype wire

[design/lpr_ctrl.sv]
// Controller: two-state sequencer that captures a reference, then runs the
// lookup and update once the result register is free. Depends on lpr_pkg.
`default_nettype none

module lpr_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire lpr_pkg::lpr_sts_t sts,
    output lpr_pkg::lpr_cmd_t      cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    assign req_ready   = (state_reg == ST_IDLE);
    assign cmd.capture = req_valid && (state_reg == ST_IDLE);
    assign cmd.exec    = (state_reg == ST_EXEC) && !sts.rsp_stalled;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold until the previous word has left the result register
                if (!sts.rsp_stalled)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[design/lpr_datapath.sv]
// Datapath: frame table, recency ranks, fault counter, lookup/victim logic
// and the result register. Depends on lpr_pkg.
`default_nettype none

module lpr_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lpr_pkg::lpr_cmd_t             cmd,
    output lpr_pkg::lpr_sts_t                  sts,
    input  wire logic [lpr_pkg::CFG_W-1:0]     frames_in_use,
    input  wire lpr_pkg::page_t                page_number,
    input  wire logic                          first_of_run,
    output logic                               rsp_valid,
    input  wire logic                          rsp_ready,
    output logic                               fault,
    output logic [lpr_pkg::FIDX_W-1:0]         frame_index,
    output logic                               evicted_valid,
    output lpr_pkg::page_t                     evicted_page,
    output lpr_pkg::fault_cnt_t                fault_count
);

    localparam int FC = lpr_pkg::FRAME_COUNT;

    // captured reference
    lpr_pkg::page_t      page_q_reg;
    logic                first_q_reg;

    // frame table
    lpr_pkg::page_t      frame_page_reg [FC];
    lpr_pkg::page_t      frame_page_next [FC];
    logic [FC-1:0]       frame_valid_reg;
    logic [FC-1:0]       frame_valid_next;
    lpr_pkg::rank_t      rank_reg [FC];
    lpr_pkg::rank_t      rank_next [FC];
    lpr_pkg::fault_cnt_t faults_reg;
    lpr_pkg::fault_cnt_t faults_next;

    // result register
    logic                            rsp_valid_reg;
    logic                            fault_reg;
    logic [lpr_pkg::FIDX_W-1:0]      frame_index_reg;
    logic                            evicted_valid_reg;
    lpr_pkg::page_t                  evicted_page_reg;
    lpr_pkg::fault_cnt_t             fault_count_reg;

    // lookup
    logic [lpr_pkg::CNT_W-1:0] act;
    logic [FC-1:0]             in_use;
    lpr_pkg::page_t            eff_page [FC];
    logic [FC-1:0]             eff_valid;
    lpr_pkg::rank_t            eff_rank [FC];
    lpr_pkg::fault_cnt_t       eff_faults;
    logic                      hit;
    logic                      found_empty;
    lpr_pkg::rank_t            hit_idx;
    lpr_pkg::rank_t            empty_idx;
    lpr_pkg::rank_t            victim_idx;
    lpr_pkg::rank_t            oldest;
    lpr_pkg::rank_t            sel_idx;
    lpr_pkg::rank_t            old_rank;
    logic                      age_all;

    assign sts.rsp_stalled = rsp_valid_reg && !rsp_ready;

    always_comb
    begin
        if (frames_in_use == '0)
        begin
            act = lpr_pkg::CNT_W'(1);
        end
        else if (32'(frames_in_use) > FC)
        begin
            act = lpr_pkg::CNT_W'(FC);
        end
        else
        begin
            act = lpr_pkg::CNT_W'(frames_in_use);
        end
    end

    // start of run: look up against an empty table
    always_comb
    begin
        for (int i = 0; i < FC; i++)
        begin
            in_use[i]    = (lpr_pkg::CNT_W'(i) < act);
            eff_page[i]  = first_q_reg ? '0 : frame_page_reg[i];
            eff_valid[i] = first_q_reg ? 1'b0 : frame_valid_reg[i];
            eff_rank[i]  = first_q_reg ? '0 : rank_reg[i];
        end
        eff_faults = first_q_reg ? '0 : faults_reg;
    end

    always_comb
    begin
        hit         = 1'b0;
        hit_idx     = '0;
        found_empty = 1'b0;
        empty_idx   = '0;
        victim_idx  = '0;
        oldest      = '0;
        for (int i = 0; i < FC; i++)
        begin
            if (!hit && in_use[i] && eff_valid[i] && (eff_page[i] == page_q_reg))
            begin
                hit     = 1'b1;
                hit_idx = lpr_pkg::IDX_W'(i);
            end
            if (!found_empty && in_use[i] && !eff_valid[i])
            begin
                found_empty = 1'b1;
                empty_idx   = lpr_pkg::IDX_W'(i);
            end
            // strict compare keeps the lowest frame among tied oldest ranks
            if (in_use[i] && (eff_rank[i] > oldest))
            begin
                oldest     = eff_rank[i];
                victim_idx = lpr_pkg::IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        priority if (hit)
        begin
            sel_idx  = hit_idx;
            age_all  = 1'b0;
        end
        else if (found_empty)
        begin
            sel_idx  = empty_idx;
            age_all  = 1'b1;
        end
        else
        begin
            sel_idx  = victim_idx;
            age_all  = 1'b0;
        end
        old_rank = eff_rank[sel_idx];
    end

    always_comb
    begin
        for (int i = 0; i < FC; i++)
        begin
            frame_page_next[i]  = eff_page[i];
            frame_valid_next[i] = eff_valid[i];
            rank_next[i]        = eff_rank[i];
            if (lpr_pkg::IDX_W'(i) == sel_idx)
            begin
                if (!hit)
                begin
                    frame_page_next[i]  = page_q_reg;
                    frame_valid_next[i] = 1'b1;
                end
                rank_next[i] = '0;
            end
            else if (in_use[i] && eff_valid[i] && (age_all || (eff_rank[i] < old_rank))
                     && (eff_rank[i] != lpr_pkg::RANK_MAX))
            begin
                rank_next[i] = eff_rank[i] + 1'b1;
            end
        end
        faults_next = eff_faults;
        if (!hit && (eff_faults != lpr_pkg::FAULT_MAX))
        begin
            faults_next = eff_faults + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            page_q_reg  <= page_number;
            first_q_reg <= first_of_run;
        end
        if (cmd.exec)
        begin
            fault_reg         <= !hit;
            frame_index_reg   <= lpr_pkg::FIDX_W'(sel_idx);
            evicted_valid_reg <= !hit && !found_empty;
            evicted_page_reg  <= (!hit && !found_empty) ? eff_page[victim_idx] : '0;
            fault_count_reg   <= faults_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= '0;
            faults_reg      <= '0;
            rsp_valid_reg   <= 1'b0;
            for (int i = 0; i < FC; i++)
            begin
                frame_page_reg[i] <= '0;
                rank_reg[i]       <= '0;
            end
        end
        else
        begin
            if (cmd.exec)
            begin
                frame_valid_reg <= frame_valid_next;
                faults_reg      <= faults_next;
                for (int i = 0; i < FC; i++)
                begin
                    frame_page_reg[i] <= frame_page_next[i];
                    rank_reg[i]       <= rank_next[i];
                end
            end
            priority if (cmd.exec)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign fault         = fault_reg;
    assign frame_index   = frame_index_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    assign fault_count   = fault_count_reg;

endmodule

`default_nettype wire

[design/lru_page_replacement_unit.sv]
// Top level of the LRU page replacement unit: register block, controller, datapath.
// Depends on lpr_pkg, lpr_req_if, lpr_rsp_if and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

// A page reference is taken on the req channel and yields exactly one result
// word on rsp: whether it faulted, the frame now holding the page, the evicted
// page if any, and the saturating fault count of the current run. Each reference
// is captured first, then the frames in use are searched in parallel to
// pick the hit, empty or least recently used frame and update the frame table.
// The update cycle waits while the previous result word is still held on rsp,
// and a new reference is accepted only after the previous one has been looked up.
// frames_in_use (address 0) limits the frames searched; write it only while idle.
module lru_page_replacement_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    lpr_req_if.sink                          req,
    lpr_rsp_if.source                        rsp,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lpr_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [lpr_pkg::DATA_W-1:0]  pwdata,
    output logic      [lpr_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    logic [lpr_pkg::CFG_W-1:0] frames_in_use;
    lpr_pkg::lpr_cmd_t         cmd;
    lpr_pkg::lpr_sts_t         sts;

    lpr_cfg_regs u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .frames_in_use (frames_in_use)
    );

    lpr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lpr_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .frames_in_use (frames_in_use),
        .page_number   (req.page_number),
        .first_of_run  (req.first_of_run),
        .rsp_valid     (rsp.valid),
        .rsp_ready     (rsp.ready),
        .fault         (rsp.fault),
        .frame_index   (rsp.frame_index),
        .evicted_valid (rsp.evicted_valid),
        .evicted_page  (rsp.evicted_page),
        .fault_count   (rsp.fault_count)
    );

    `LPR_ASSERT_NXT(a_busy_after_accept, clk, rst_n, req.valid && req.ready, !req.ready, "reference accepted while previous one still in lookup")
    `LPR_ASSERT_IMP(a_hit_no_evict, clk, rst_n, rsp.valid && !rsp.fault, !rsp.evicted_valid, "eviction reported on a hit")
    `LPR_ASSERT_IMP(a_evict_page_zero, clk, rst_n, rsp.valid && !rsp.evicted_valid, rsp.evicted_page == '0, "evicted page nonzero with no eviction")
    `LPR_ASSERT_IMP(a_fault_count_nonzero, clk, rst_n, rsp.valid && rsp.fault, rsp.fault_count != '0, "fault reported with zero fault count")

endmodule

`default_nettype wire
